@@ design/rcfp_pkg.sv @@
// rcfp_pkg: shared constants and types of the RC channel frame parser.
// No dependencies; imported by every module of the block.
package rcfp_pkg;

    // frame layout
    localparam int NUM_CHANNELS  = 16;
    localparam int CHANNEL_BITS  = 11;
    localparam int CH_IDX_W      = $clog2(NUM_CHANNELS);
    localparam int PAYLOAD_BYTES = (NUM_CHANNELS * CHANNEL_BITS) / 8;
    localparam int FRAME_W       = NUM_CHANNELS * CHANNEL_BITS;
    localparam logic [7:0] FRAME_LENGTH = 8'(PAYLOAD_BYTES + 2);

    // CRC-8, polynomial 0xD5, MSB first
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TYPE = CFG_IDX_W'(1);
    localparam logic [7:0] SYNC_RESET = 8'hEE;
    localparam logic [7:0] TYPE_RESET = 8'h16;

    // frame queue depth between parser and drain
    localparam int Q_DEPTH = 2;

    // parser phases
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_TYPE,
        PH_PAYLOAD,
        PH_CRC
    } t_phase;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ design/rcfp_front.sv @@
// rcfp_front: byte parser. Hunts sync, checks length/type, unpacks channels, runs CRC.
// Depends on rcfp_pkg. Pushes a channel snapshot word into the frame queue on a good CRC.
module rcfp_front
    import rcfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_rx_valid,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_rx_ready,
    input  t_q_stat              i_q_stat,
    output logic                 o_push,
    output logic [FRAME_W-1:0]   o_push_data
);

    localparam int BUF_W  = CHANNEL_BITS - 1;   // at most 10 bits left over
    localparam int ACC_W  = BUF_W + 8;
    localparam int FILL_W = $clog2(CHANNEL_BITS);
    localparam int CNT_W  = 5;

    // one CRC-8 byte step
    function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    t_phase              r_phase, n_phase;
    logic [7:0]          r_sync, r_type;
    logic [7:0]          r_crc;
    logic [BUF_W-1:0]    r_buf;
    logic [FILL_W-1:0]   r_fill;
    logic [CNT_W-1:0]    r_byte_cnt;
    logic [CNT_W-1:0]    r_ch_cnt;
    logic [CHANNEL_BITS-1:0] r_store [NUM_CHANNELS];

    logic                accept;
    logic [7:0]          crc_next;
    logic [ACC_W-1:0]    acc;
    logic [FILL_W:0]     fill_sum;
    logic                take;
    logic [BUF_W-1:0]    n_buf;
    logic [FILL_W-1:0]   n_fill;

    // hold the input only at the CRC byte when no queue slot is free
    assign o_rx_ready = !((r_phase == PH_CRC) && i_q_stat.full);
    assign accept     = i_rx_valid && o_rx_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
            r_type <= TYPE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_SYNC) begin
                r_sync <= i_cfg_data;
            end else if (i_cfg_index == REG_TYPE) begin
                r_type <= i_cfg_data;
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                PH_HUNT:    n_phase = (i_rx_byte == r_sync) ? PH_LEN : PH_HUNT;
                PH_LEN:     n_phase = (i_rx_byte == FRAME_LENGTH) ? PH_TYPE : PH_HUNT;
                PH_TYPE:    n_phase = (i_rx_byte == r_type) ? PH_PAYLOAD : PH_HUNT;
                PH_PAYLOAD: begin
                    if (r_byte_cnt >= CNT_W'(PAYLOAD_BYTES - 1)) begin
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC:     n_phase = PH_HUNT;
                default:    n_phase = PH_HUNT;
            endcase
        end
    end

    // CRC and bit unpacking datapath
    always_comb begin
        crc_next = crc_step((r_phase == PH_TYPE) ? 8'h00 : r_crc, i_rx_byte);
        acc      = ACC_W'(r_buf) | (ACC_W'(i_rx_byte) << r_fill);
        fill_sum = {1'b0, r_fill} + (FILL_W + 1)'(8);
        take     = fill_sum >= (FILL_W + 1)'(CHANNEL_BITS);
        if (take) begin
            n_buf  = BUF_W'(acc >> CHANNEL_BITS);
            n_fill = FILL_W'(fill_sum - (FILL_W + 1)'(CHANNEL_BITS));
        end else begin
            n_buf  = acc[BUF_W-1:0];
            n_fill = fill_sum[FILL_W-1:0];
        end
    end

    // push a snapshot of the store on a zero residue
    assign o_push = accept && (r_phase == PH_CRC) && (crc_next == 8'h00);

    always_comb begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            o_push_data[k*CHANNEL_BITS +: CHANNEL_BITS] = r_store[k];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_crc      <= 8'h00;
            r_buf      <= '0;
            r_fill     <= '0;
            r_byte_cnt <= '0;
            r_ch_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            if (accept && (r_phase == PH_TYPE)) begin
                r_crc      <= crc_next;
                r_buf      <= '0;
                r_fill     <= '0;
                r_byte_cnt <= '0;
                r_ch_cnt   <= '0;
            end else if (accept && (r_phase == PH_PAYLOAD)) begin
                r_crc      <= crc_next;
                r_buf      <= n_buf;
                r_fill     <= n_fill;
                r_byte_cnt <= r_byte_cnt + CNT_W'(1);
                if (take) begin
                    r_ch_cnt <= r_ch_cnt + CNT_W'(1);
                end
            end else if (accept && (r_phase == PH_CRC)) begin
                r_crc <= crc_next;
            end
        end
    end

    // channel store, no reset
    always_ff @(posedge i_clk) begin
        if (accept && (r_phase == PH_PAYLOAD) && take
            && (r_ch_cnt < CNT_W'(NUM_CHANNELS))) begin
            r_store[r_ch_cnt[CH_IDX_W-1:0]] <= acc[CHANNEL_BITS-1:0];
        end
    end

endmodule

@@ design/rcfp_queue.sv @@
// rcfp_queue: short queue of good-frame channel snapshots between parser and drain.
// Depends on rcfp_pkg.
module rcfp_queue
    import rcfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [FRAME_W-1:0] i_push_data,
    input  logic               i_pop,
    output logic [FRAME_W-1:0] o_head,
    output t_q_stat            o_stat
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [FRAME_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_stat.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_stat.full)
        else $error("frame queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("frame queue pop while empty");
`endif

endmodule

@@ design/rcfp_drain.sv @@
// rcfp_drain: walks the head snapshot out as sixteen channel words through an output register.
// Depends on rcfp_pkg; pops the queue as the last channel is loaded.
module rcfp_drain
    import rcfp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [FRAME_W-1:0]      i_head,
    input  t_q_stat                 i_q_stat,
    output logic                    o_pop,
    output logic                    o_ch_valid,
    input  logic                    i_ch_ready,
    output logic [CH_IDX_W-1:0]     o_channel_index,
    output logic [CHANNEL_BITS-1:0] o_channel_value,
    output logic                    o_last_channel
);

    localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(NUM_CHANNELS - 1);

    logic                    r_valid;
    logic [CH_IDX_W-1:0]     r_idx;
    logic [CH_IDX_W-1:0]     r_index;
    logic [CHANNEL_BITS-1:0] r_value;
    logic                    r_last;
    logic                    load;

    // load a new word when the output register is free or being taken
    assign load  = !i_q_stat.empty && (!r_valid || i_ch_ready);
    assign o_pop = load && (r_idx == LAST_IDX);

    // valid and channel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= r_idx + CH_IDX_W'(1);
        end else if (i_ch_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_index <= r_idx;
            r_value <= i_head[r_idx*CHANNEL_BITS +: CHANNEL_BITS];
            r_last  <= (r_idx == LAST_IDX);
        end
    end

    assign o_ch_valid      = r_valid;
    assign o_channel_index = r_index;
    assign o_channel_value = r_value;
    assign o_last_channel  = r_last;

`ifndef SYNTHESIS
    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_index == LAST_IDX))
        else $error("last mark on a channel other than the final one");
    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ch_ready && !r_last) |=>
            (!r_valid || (r_index == $past(r_index) + CH_IDX_W'(1))))
        else $error("channel index skipped within a frame");
`endif

endmodule

@@ design/rc_channel_frame_parser_top.sv @@
// A good CRC byte pushes its frame into the queue, then the drain registers its first word.
// Throughput: one byte per cycle; each good frame drains 16 words, one per ready cycle.
// The input holds only at a CRC byte while two good frames still wait in the queue.
// Reset: i_rst_n synchronous active low; parser hunts for sync, queue and output clear,
// registers take 0xEE / 0x16, the channel store holds no defined value until written.
module rc_channel_frame_parser_top
    import rcfp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]              i_cfg_data,
    input  logic                    i_rx_valid,
    output logic                    o_rx_ready,
    input  logic [7:0]              i_rx_byte,
    output logic                    o_ch_valid,
    input  logic                    i_ch_ready,
    output logic [CH_IDX_W-1:0]     o_channel_index,
    output logic [CHANNEL_BITS-1:0] o_channel_value,
    output logic                    o_last_channel
);

    logic               push;
    logic [FRAME_W-1:0] push_data;
    logic               pop;
    logic [FRAME_W-1:0] head;
    t_q_stat            q_stat;

    // byte parser
    rcfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .o_rx_ready  (o_rx_ready),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // good-frame queue
    rcfp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    // channel drain
    rcfp_drain u_drain (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_stat        (q_stat),
        .o_pop           (pop),
        .o_ch_valid      (o_ch_valid),
        .i_ch_ready      (i_ch_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

endmodule
